### rtl/cwsr_pkg.sv
// ----------------------------------------------------------------------------
// cwsr_pkg
// Shared types and constants of the clock working set replacer.
// ----------------------------------------------------------------------------
package cwsr_pkg;

  localparam int WS_SLOTS   = 32;
  localparam int PAGE_SHIFT = 12;

  localparam int SLOT_W = $clog2(WS_SLOTS);
  localparam int SIZE_W = $clog2(WS_SLOTS + 1);

  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = 20;
  localparam int SLOT_FLD_W = 5;
  localparam int WSMAX_W    = 6;
  localparam int BOUND_W    = 21;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 21;

  localparam logic [WSMAX_W-1:0] WS_MAX_RESET = WSMAX_W'(32);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WS_MAX_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SWEEP,
    ST_VICTIM,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic do_access;
    logic set_illegal;
    logic scan_start;
    logic scan_next;
    logic sweep_start;
    logic sweep_clear;
    logic place;
    logic evict;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_fault;
    logic illegal;
    logic ptr_lt_size;
    logic ptr_valid;
    logic ptr_used;
    logic out_free;
  } status_t;

  // Result word, laid out as on m_tdata (lowest field last)
  typedef struct packed {
    logic [2:0]            pad;
    logic                  illegal;
    logic                  write_back;
    logic [PAGE_W-1:0]     victim_page;
    logic                  evicted;
    logic                  placed;
    logic [SLOT_FLD_W-1:0] placed_slot;
  } result_t;

endpackage

### rtl/cwsr_ctrl.sv
// ----------------------------------------------------------------------------
// cwsr_ctrl
// Sequencer for access, fault check, free-slot scan and clock sweep.
// ----------------------------------------------------------------------------
module cwsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  cwsr_pkg::status_t st,
  output cwsr_pkg::cmd_t    cmd
);
  import cwsr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!st.is_fault) begin
          cmd.do_access = 1'b1;
          state_next    = ST_EMIT;
        end else if (st.illegal) begin
          cmd.set_illegal = 1'b1;
          state_next      = ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // set full: fall back to the clock sweep
        if (!st.ptr_lt_size) begin
          cmd.sweep_start = 1'b1;
          state_next      = ST_SWEEP;
        end else if (!st.ptr_valid) begin
          cmd.place  = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_SWEEP: begin
        // hold the pointer on the victim so its page reads out next cycle
        if (st.ptr_used) begin
          cmd.sweep_clear = 1'b1;
        end else begin
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        cmd.evict  = 1'b1;
        cmd.place  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/cwsr_datapath.sv
// ----------------------------------------------------------------------------
// cwsr_datapath
// Configuration registers, slot flags, page memory, clock hand and the
// result and output registers.
// ----------------------------------------------------------------------------
module cwsr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [cwsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cwsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [cwsr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cwsr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  cwsr_pkg::cmd_t                      cmd,
  output cwsr_pkg::status_t                   st
);
  import cwsr_pkg::*;

  // configuration
  logic [WSMAX_W-1:0] ws_max_size;
  logic [BOUND_W-1:0] stack_bottom_page;
  logic [BOUND_W-1:0] stack_top_page;
  logic [BOUND_W-1:0] heap_start_page;
  logic [BOUND_W-1:0] heap_end_page;

  // captured item
  logic                  kind;
  logic [ADDR_W-1:0]     fault_address;
  logic [SLOT_FLD_W-1:0] access_slot;
  logic                  is_write;
  logic                  in_backing_store;

  // slot state
  logic [WS_SLOTS-1:0] slot_valid;
  logic [WS_SLOTS-1:0] slot_used;
  logic [WS_SLOTS-1:0] slot_modified;
  logic [PAGE_W-1:0]   page_mem [WS_SLOTS];
  logic [PAGE_W-1:0]   rd_page;
  logic [SLOT_W-1:0]   clock_hand;
  logic [SIZE_W-1:0]   ptr;

  result_t res;
  result_t out_res;

  logic [SIZE_W-1:0] size;
  logic [SLOT_W-1:0] ptr_idx;
  logic [SIZE_W-1:0] ptr_inc;
  logic [SIZE_W-1:0] ptr_wrap;
  logic [ADDR_W-1:0] page_full;
  logic [SLOT_W-1:0] acc_idx;
  logic              acc_ok;
  logic              in_stack;
  logic              in_heap;

  always_comb begin
    if (ws_max_size == '0) begin
      size = SIZE_W'(1);
    end else if (32'(ws_max_size) > WS_SLOTS) begin
      size = SIZE_W'(WS_SLOTS);
    end else begin
      size = SIZE_W'(ws_max_size);
    end
  end

  assign ptr_idx   = ptr[SLOT_W-1:0];
  assign ptr_inc   = ptr + SIZE_W'(1);
  assign ptr_wrap  = (ptr_inc == size) ? '0 : ptr_inc;
  assign page_full = fault_address >> PAGE_SHIFT;
  assign in_stack  = (page_full >= ADDR_W'(stack_bottom_page)) &&
                     (page_full <  ADDR_W'(stack_top_page));
  assign in_heap   = (page_full >= ADDR_W'(heap_start_page)) &&
                     (page_full <  ADDR_W'(heap_end_page));
  assign acc_idx   = SLOT_W'(access_slot);
  assign acc_ok    = (32'(access_slot) < WS_SLOTS) && slot_valid[acc_idx];

  assign st.is_fault    = kind;
  assign st.illegal     = !in_backing_store && !in_stack && !in_heap;
  assign st.ptr_lt_size = ptr < size;
  assign st.ptr_valid   = slot_valid[ptr_idx];
  assign st.ptr_used    = slot_used[ptr_idx];
  assign st.out_free    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws_max_size       <= WS_MAX_RESET;
      stack_bottom_page <= '0;
      stack_top_page    <= '0;
      heap_start_page   <= '0;
      heap_end_page     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_WS_MAX_SIZE:  ws_max_size       <= cfg_data[WSMAX_W-1:0];
        REG_STACK_BOTTOM: stack_bottom_page <= cfg_data;
        REG_STACK_TOP:    stack_top_page    <= cfg_data;
        REG_HEAP_START:   heap_start_page   <= cfg_data;
        REG_HEAP_END:     heap_end_page     <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture (fields of s_tdata from the lowest bit up)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind             <= s_tuser;
      fault_address    <= s_tdata[31:0];
      access_slot      <= s_tdata[36:32];
      is_write         <= s_tdata[37];
      in_backing_store <= s_tdata[38];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      slot_used     <= '0;
      slot_modified <= '0;
      clock_hand    <= '0;
    end else begin
      if (cmd.do_access && acc_ok) begin
        slot_used[acc_idx] <= 1'b1;
        if (is_write) begin
          slot_modified[acc_idx] <= 1'b1;
        end
      end
      if (cmd.sweep_clear) begin
        slot_used[ptr_idx] <= 1'b0;
      end
      if (cmd.place) begin
        slot_valid[ptr_idx]    <= 1'b1;
        slot_used[ptr_idx]     <= 1'b1;
        slot_modified[ptr_idx] <= 1'b0;
        clock_hand             <= SLOT_W'(ptr_wrap);
      end
    end
  end

  // scan / sweep pointer
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= '0;
    end else if (cmd.scan_next) begin
      ptr <= ptr_inc;
    end else if (cmd.sweep_start) begin
      ptr <= (SIZE_W'(clock_hand) < size) ? SIZE_W'(clock_hand) : '0;
    end else if (cmd.sweep_clear) begin
      ptr <= ptr_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      page_mem[ptr_idx] <= page_full[PAGE_W-1:0];
    end
    rd_page <= page_mem[ptr_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res <= '0;
    end else begin
      if (cmd.set_illegal) begin
        res.illegal <= 1'b1;
      end
      if (cmd.place) begin
        res.placed      <= 1'b1;
        res.placed_slot <= SLOT_FLD_W'(ptr);
      end
      if (cmd.evict) begin
        res.evicted     <= 1'b1;
        res.victim_page <= rd_page;
        res.write_back  <= slot_modified[ptr_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res;

endmodule

### rtl/clock_working_set_replacer_unit.sv
// ----------------------------------------------------------------------------
// clock_working_set_replacer_unit
// Clock page replacement over a working set of page slots.
//
//   channel | dir | handshake          | payload
//   s       | in  | s_tvalid/s_tready  | s_tdata, s_tuser (access or fault)
//   m       | out | m_tvalid/m_tready  | m_tdata (one result per item)
//   cfg     | in  | cfg_wen            | cfg_index, cfg_data
//
// Access and illegal-fault items go from the check state straight to the emit
// state. A legal fault scans the slots below the size in use for a free one,
// one slot a cycle, then, when the set is full, sweeps the clock hand, one slot
// a cycle; an output stall can hold any result in the emit state.
// One item is in work at a time; the output register holds a result while
// the next item is taken. Reset is synchronous and clears all slot flags.
// ----------------------------------------------------------------------------
module clock_working_set_replacer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fault_address[31:0], access_slot[36:32], is_write[37],
  // in_backing_store[38], zero[39]
  input  logic [cwsr_pkg::IN_TDATA_W-1:0]      s_tdata,
  // kind[0]
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // placed_slot[4:0], placed[5], evicted[6], victim_page[26:7],
  // write_back[27], illegal[28], zero[31:29]
  output logic [cwsr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_wen,
  input  logic [cwsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cwsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cwsr_pkg::*;

  cmd_t    cmd;
  status_t st;

  cwsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cwsr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .st        (st)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  a_evict_places: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> cmd.place)
    else $error("victim reported without placing the fault");

  a_sweep_used: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_clear |-> (st.ptr_used && st.ptr_lt_size))
    else $error("sweep cleared an unused or out-of-range slot");

  a_busy_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !s_tready)
    else $error("new item taken while one is in work");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock working set replacer. Page accesses and
// page faults stream in with bursts and gaps while the result side stalls.
// A local model of the slot ring, the clock hand and the legal regions
// predicts each result, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cwsr_pkg::*;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_FAULT  = 1'b1;

  localparam int RX_STEADY = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_BURSTY = 2;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 2 * WS_SLOTS + 16;
  localparam int unsigned PAGE_SPAN = 1 << PAGE_W;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic                  kind;
    logic [ADDR_W-1:0]     addr;
    logic [SLOT_FLD_W-1:0] slot;
    logic                  wr;
    logic                  backed;
    bit                    drain;  // hold this one until every result is back
  } page_req_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_WS_MAX_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  clock_working_set_replacer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow registers and slot ring of the model
  logic [WSMAX_W-1:0] ws_size;
  logic [BOUND_W-1:0] stack_lo, stack_hi, heap_lo, heap_hi;
  logic               res_valid [WS_SLOTS];
  logic [PAGE_W-1:0]  res_page  [WS_SLOTS];
  logic               res_used  [WS_SLOTS];
  logic               res_dirty [WS_SLOTS];
  int unsigned        hand;

  page_req_t page_reqs[$];
  result_t   due_results[$];
  page_req_t tx_cur;
  bit        s_taken = 1'b0;
  int        tx_burst = 1;
  int        tx_gap = 0;
  int        rx_mode = RX_STEADY;
  int        rx_stall = 0;
  int unsigned rx_tick = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_size();
    if (ws_size == 0) return 1;
    if (ws_size > WS_SLOTS) return WS_SLOTS;
    return ws_size;
  endfunction

  // Apply one accepted item to the ring and return the result it causes
  function automatic result_t clock_replace(input page_req_t r);
    result_t     res;
    int unsigned sz, pg, pos, n;
    int          victim;
    bit          in_stack, in_heap;
    res = '0;
    if (r.kind == KIND_ACCESS) begin
      if (res_valid[r.slot]) begin
        res_used[r.slot] = 1'b1;
        if (r.wr) res_dirty[r.slot] = 1'b1;
      end
      return res;
    end
    pg = r.addr >> PAGE_SHIFT;
    in_stack = pg >= stack_lo && pg < stack_hi;
    in_heap = pg >= heap_lo && pg < heap_hi;
    if (!r.backed && !in_stack && !in_heap) begin
      res.illegal = 1'b1;
      return res;
    end
    sz = eff_size();
    victim = -1;
    for (int i = 0; i < sz; i++)
      if (victim < 0 && !res_valid[i]) victim = i;
    if (victim < 0) begin
      // sweep from the hand, clearing used bits; wraps at most twice
      pos = (hand < sz) ? hand : 0;
      for (n = 0; n < 2 * sz && victim < 0; n++) begin
        if (res_used[pos]) begin
          res_used[pos] = 1'b0;
          pos = (pos + 1) % sz;
        end else begin
          victim = pos;
          res.evicted = 1'b1;
          res.victim_page = res_page[pos];
          res.write_back = res_dirty[pos];
        end
      end
    end
    res_valid[victim] = 1'b1;
    res_page[victim] = PAGE_W'(pg);
    res_used[victim] = 1'b1;
    res_dirty[victim] = 1'b0;
    hand = (victim + 1) % sz;
    res.placed = 1'b1;
    res.placed_slot = SLOT_FLD_W'(victim);
    return res;
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic page_req_t mk_access(input int slot, input logic wr);
    page_req_t r;
    r.kind = KIND_ACCESS;
    r.addr = $urandom();
    r.slot = SLOT_FLD_W'(slot);
    r.wr = wr;
    r.backed = 1'($urandom_range(0, 1));
    r.drain = 1'b0;
    return r;
  endfunction

  function automatic page_req_t mk_fault(input logic [ADDR_W-1:0] addr, input logic backed);
    page_req_t r;
    r.kind = KIND_FAULT;
    r.addr = addr;
    r.slot = SLOT_FLD_W'($urandom_range(0, 31));
    r.wr = 1'($urandom_range(0, 1));
    r.backed = backed;
    r.drain = 1'b0;
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] page_in(input int unsigned lo, input int unsigned hi);
    if (hi > PAGE_SPAN) hi = PAGE_SPAN;
    if (hi <= lo) return PAGE_W'($urandom());
    return PAGE_W'(lo + $urandom_range(0, hi - lo - 1));
  endfunction

  function automatic page_req_t random_req(input int fault_pct);
    logic [PAGE_W-1:0] pg;
    int                slot;
    if ($urandom_range(0, 99) < fault_pct) begin
      case ($urandom_range(0, 3))
        0: pg = PAGE_W'($urandom());
        1: pg = page_in(stack_lo, stack_hi);
        2: pg = page_in(heap_lo, heap_hi);
        default: begin
          // land on or next to a region bound
          case ($urandom_range(0, 5))
            0: pg = PAGE_W'(stack_lo);
            1: pg = PAGE_W'(stack_hi - 1);
            2: pg = PAGE_W'(stack_hi);
            3: pg = PAGE_W'(heap_lo);
            4: pg = PAGE_W'(heap_hi - 1);
            default: pg = PAGE_W'(heap_hi);
          endcase
        end
      endcase
      return mk_fault({pg, PAGE_SHIFT'($urandom())}, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 4) == 0) slot = $urandom_range(0, 31);
    else slot = $urandom_range(0, eff_size() - 1);
    return mk_access(slot, 1'($urandom_range(0, 1)));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_WS_MAX_SIZE:  ws_size = WSMAX_W'(val);
      REG_STACK_BOTTOM: stack_lo = val;
      REG_STACK_TOP:    stack_hi = val;
      REG_HEAP_START:   heap_lo = val;
      REG_HEAP_END:     heap_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int size, input int sl, input int sh, input int hl,
                            input int hh);
    write_reg(REG_WS_MAX_SIZE, CFG_DATA_W'(size));
    write_reg(REG_STACK_BOTTOM, CFG_DATA_W'(sl));
    write_reg(REG_STACK_TOP, CFG_DATA_W'(sh));
    write_reg(REG_HEAP_START, CFG_DATA_W'(hl));
    write_reg(REG_HEAP_END, CFG_DATA_W'(hh));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (page_reqs.size() != 0 || s_tvalid || due_results.size() != 0);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!s_tvalid || s_taken) begin
      s_taken = 1'b0;
      if (tx_gap != 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (page_reqs.size() != 0 &&
                   !(page_reqs[0].drain && due_results.size() != 0)) begin
        tx_cur = page_reqs.pop_front();
        s_tuser <= tx_cur.kind;
        s_tdata <= {1'b0, tx_cur.backed, tx_cur.wr, tx_cur.slot, tx_cur.addr};
        s_tvalid <= 1'b1;
        if (tx_burst > 1) begin
          tx_burst--;
        end else begin
          tx_burst = $urandom_range(1, 16);
          tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall style is picked at random from steady, choppy and bursty
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(RX_STEADY, RX_BURSTY);
    if (rx_stall != 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(1, 20);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) $error("result with none pending: 0x%0h", m_tdata);
        end else begin
          want = due_results.pop_front();
          cmp_field("placed_slot", want.placed_slot, got.placed_slot);
          cmp_field("placed", want.placed, got.placed);
          cmp_field("evicted", want.evicted, got.evicted);
          cmp_field("victim_page", want.victim_page, got.victim_page);
          cmp_field("write_back", want.write_back, got.write_back);
          cmp_field("illegal", want.illegal, got.illegal);
        end
      end
      if (s_tvalid && s_tready) begin
        due_results.push_back(clock_replace(tx_cur));
        s_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("[clock_working_set_replacer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int n_items, drain_at;
    page_req_t r;
    ws_size = WS_MAX_RESET;
    stack_lo = '0;
    stack_hi = '0;
    heap_lo = '0;
    heap_hi = '0;
    hand = 0;
    for (int i = 0; i < WS_SLOTS; i++) begin
      res_valid[i] = 1'b0;
      res_page[i] = '0;
      res_used[i] = 1'b0;
      res_dirty[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: full size, no legal region
    page_reqs.push_back(mk_access(0, 1'b1));
    page_reqs.push_back(mk_fault(32'h1234_5678, 1'b0));
    page_reqs.push_back(mk_fault(32'h0000_0000, 1'b1));
    wait_idle();

    // Four slots, stack [0x100, 0x200), heap [0x80000, 0x100000)
    set_config(4, 'h100, 'h200, 'h80000, 'h100000);
    page_reqs.push_back(mk_fault(32'hFFFF_FFFF, 1'b1));
    page_reqs.push_back(mk_fault(32'h0010_0000, 1'b0));
    page_reqs.push_back(mk_fault(32'h001F_FFFF, 1'b0));
    page_reqs.push_back(mk_fault(32'h0020_0000, 1'b0));
    page_reqs.push_back(mk_fault(32'h000F_FFFF, 1'b0));
    page_reqs.push_back(mk_fault(32'h7FFF_FFFF, 1'b0));
    // every used bit set: the sweep wraps all the way round
    page_reqs.push_back(mk_fault(32'h8000_0000, 1'b0));
    page_reqs.push_back(mk_access(1, 1'b1));
    page_reqs.push_back(mk_access(2, 1'b0));
    page_reqs.push_back(mk_access(31, 1'b1));
    page_reqs.push_back(mk_fault(32'h0000_0ABC, 1'b1));
    page_reqs.push_back(mk_fault(32'hFFFF_F000, 1'b0));
    page_reqs.push_back(mk_access(3, 1'b1));
    page_reqs.push_back(mk_access(0, 1'b1));
    // a resident page faults again
    page_reqs.push_back(mk_fault(32'h0010_0000, 1'b1));
    page_reqs.push_back(mk_fault(32'h5A5A_5A5A, 1'b1));
    wait_idle();

    // A size of zero acts as one slot
    write_reg(REG_WS_MAX_SIZE, CFG_DATA_W'(0));
    page_reqs.push_back(mk_fault(32'hA5A5_A5A5, 1'b1));
    page_reqs.push_back(mk_fault(32'h0000_1000, 1'b1));
    wait_idle();

    // A size above the ring acts as the whole ring
    write_reg(REG_WS_MAX_SIZE, CFG_DATA_W'(63));
    page_reqs.push_back(mk_fault(32'hC000_0000, 1'b1));
    page_reqs.push_back(mk_access(4, 1'b1));
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(1, 0, 0, 0, 'h100000);
        1: set_config(32, 0, 'h400, 'hFFC00, 'h1FFFFF);
        2: set_config(5, 'h300, 'h100, 'h40000, 'h40100);   // shrink, stack empty
        3: set_config(63, 'h100000, 'h100000, 'h10, 'h20);
        4: set_config(0, 'h1FFFFF, 'h1FFFFF, 0, 0);
        5: begin
          stack_lo = BOUND_W'($urandom_range(0, 'hFFFFF));
          heap_lo = BOUND_W'($urandom_range(0, 'hFFFFF));
          set_config($urandom_range(2, 8), stack_lo, stack_lo + $urandom_range(0, 'h1000),
                     heap_lo, heap_lo + $urandom_range(0, 'h1000));
        end
        default: begin
          stack_lo = BOUND_W'($urandom_range(0, 'hFFFFF));
          heap_lo = BOUND_W'($urandom_range(0, 'hFFFFF));
          set_config($urandom_range(9, 31), stack_lo, stack_lo + $urandom_range(0, 'h1000),
                     heap_lo, heap_lo + $urandom_range(0, 'h1000));
        end
      endcase
      n_items = (ph == 1) ? 110 : 90;
      drain_at = $urandom_range(n_items / 4, 3 * n_items / 4);
      for (int i = 0; i < n_items; i++) begin
        r = random_req((ph == 1) ? 60 : 40);
        r.drain = (i == drain_at);
        page_reqs.push_back(r);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0)
      $display("[clock_working_set_replacer_unit] OK");
    else
      $display("[clock_working_set_replacer_unit] ERROR");
    $finish;
  end

endmodule
